// ----- src/bljt_pkg.sv -----
// Package for the binary lifting jump table.
// Field widths, register map, sequencer states and the status struct.
// Depends on nothing; every other file of the block imports it.
package bljt_pkg;

	// Default geometry of the jump table.
	localparam int NODES_DEF  = 1024;
	localparam int LEVELS_DEF = 16;

	// Widths of the beat fields, fixed by the interface.
	localparam int NODE_W  = 10;
	localparam int COUNT_W = 16;
	localparam int CFG_W   = 11;

	// Configuration port.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam int NODE_COUNT_RST = 1024;

	// Item kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLAMP_RD,
		ST_CLAMP_WR,
		ST_LIFT_RD1,
		ST_LIFT_RD2,
		ST_LIFT_WR,
		ST_Q_STEP,
		ST_Q_LOAD,
		ST_Q_DONE
	} bljt_state_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} bljt_status_t;

endpackage

// ----- src/bljt_table_ram.sv -----
// Single write port, single registered read port memory for the jump table.
// Depends on bljt_pkg for its default parameters; it is otherwise a generic RAM.
module bljt_table_ram
	import bljt_pkg::*;
#(
	parameter int DEPTH = NODES_DEF * LEVELS_DEF,
	parameter int AW    = $clog2(NODES_DEF * LEVELS_DEF),
	parameter int DW    = $clog2(NODES_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/bljt_ctrl.sv -----
// Sequencer of the jump table: loads, table build and query walk.
// Depends on bljt_pkg and drives one bljt_table_ram through a shared clamp compare.
module bljt_ctrl
	import bljt_pkg::*;
#(
	parameter int NODES  = NODES_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          kind,
	input  logic [NODE_W-1:0]             node,
	input  logic [NODE_W-1:0]             successor,
	input  logic [COUNT_W-1:0]            jump_count,
	input  logic                          last,
	input  logic [$clog2(NODES+1)-1:0]    live_n,
	input  logic                          res_take,
	output bljt_status_t                  status,
	output logic [NODE_W-1:0]             res_node
);

	localparam int NW    = $clog2(NODES);
	localparam int CW    = $clog2(NODES + 1);
	localparam int JW    = $clog2(LEVELS + 1);
	localparam int VW    = (NW > NODE_W) ? NW : NODE_W;
	localparam int DEPTH = LEVELS * NODES;
	localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int QL    = (LEVELS < COUNT_W) ? LEVELS : COUNT_W;

	bljt_state_t state_q, state_d;
	logic [CW-1:0]      i_q, i_d;
	logic [JW-1:0]      j_q, j_d;
	logic [VW-1:0]      pos_q, pos_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic               ready_q, ready_d;

	logic          we;
	logic [JW-1:0] wlvl, rlvl;
	logic [NW-1:0] widx, ridx, wdata, rdata;
	logic [VW-1:0] clamp_in;
	logic [NW-1:0] clamp_out, nm1;
	logic          i_last;

	function automatic logic [AW-1:0] tbl_addr(input logic [JW-1:0] lvl,
		input logic [NW-1:0] idx);
		return AW'(AW'(lvl) * AW'(NODES)) + AW'(idx);
	endfunction

	// The shared clamp compare: clamps a node number into the live range.
	assign nm1       = NW'(live_n - CW'(1));
	assign clamp_out = (32'(clamp_in) >= 32'(live_n)) ? nm1 : NW'(clamp_in);
	assign i_last    = (i_q == live_n - CW'(1));
	assign res_node  = NODE_W'(pos_q);

	bljt_table_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.DW   (NW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(tbl_addr(wlvl, widx)),
		.wdata(wdata),
		.raddr(tbl_addr(rlvl, ridx)),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			ready_q <= ready_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		cnt_q <= cnt_d;
	end

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		pos_d   = pos_q;
		cnt_d   = cnt_q;
		ready_d = ready_q;
		we       = 1'b0;
		wlvl     = '0;
		widx     = i_q[NW-1:0];
		rlvl     = '0;
		ridx     = i_q[NW-1:0];
		clamp_in = VW'(node);
		wdata    = clamp_out;
		status.idle      = 1'b0;
		status.res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				status.idle = 1'b1;
				if (kind == KIND_LOAD) begin
					clamp_in = VW'(successor);
				end
				if (accept) begin
					if (kind == KIND_LOAD) begin
						if (32'(node) < 32'(live_n)) begin
							we   = 1'b1;
							widx = NW'(node);
						end
						if (last) begin
							i_d     = '0;
							state_d = ST_CLAMP_RD;
						end
					end else if (ready_q) begin
						pos_d   = VW'(clamp_out);
						cnt_d   = jump_count;
						j_d     = '0;
						state_d = ST_Q_STEP;
					end else begin
						pos_d   = VW'(node);
						state_d = ST_Q_DONE;
					end
				end
			end
			ST_CLAMP_RD: begin
				state_d = ST_CLAMP_WR;
			end
			ST_CLAMP_WR: begin
				clamp_in = VW'(rdata);
				we       = 1'b1;
				if (i_last) begin
					i_d = '0;
					if (LEVELS > 1) begin
						j_d     = JW'(1);
						state_d = ST_LIFT_RD1;
					end else begin
						ready_d = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					i_d     = i_q + CW'(1);
					state_d = ST_CLAMP_RD;
				end
			end
			ST_LIFT_RD1: begin
				rlvl    = j_q - JW'(1);
				state_d = ST_LIFT_RD2;
			end
			ST_LIFT_RD2: begin
				rlvl    = j_q - JW'(1);
				ridx    = rdata;
				state_d = ST_LIFT_WR;
			end
			ST_LIFT_WR: begin
				we    = 1'b1;
				wlvl  = j_q;
				wdata = rdata;
				if (i_last) begin
					i_d = '0;
					if (j_q == JW'(LEVELS - 1)) begin
						ready_d = 1'b1;
						state_d = ST_IDLE;
					end else begin
						j_d     = j_q + JW'(1);
						state_d = ST_LIFT_RD1;
					end
				end else begin
					i_d     = i_q + CW'(1);
					state_d = ST_LIFT_RD1;
				end
			end
			ST_Q_STEP: begin
				if (j_q == JW'(QL)) begin
					state_d = ST_Q_DONE;
				end else if (cnt_q[0]) begin
					rlvl    = j_q;
					ridx    = NW'(pos_q);
					state_d = ST_Q_LOAD;
				end else begin
					j_d   = j_q + JW'(1);
					cnt_d = cnt_q >> 1;
				end
			end
			ST_Q_LOAD: begin
				pos_d   = VW'(rdata);
				j_d     = j_q + JW'(1);
				cnt_d   = cnt_q >> 1;
				state_d = ST_Q_STEP;
			end
			ST_Q_DONE: begin
				status.res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/binary_lifting_jump_table.sv -----
// Top level of the binary lifting jump table: request and result channels,
// configuration register and result register.
// Depends on bljt_pkg and bljt_ctrl (which holds bljt_table_ram).
//
// Use: a request beat carries kind, node, successor, jump_count and last.
// A load beat (kind 0) writes the clamped successor of node into level 0 of the
// table in the cycle it is accepted, if node is below the live count; a load beat
// with last set then starts the table build, which clamps level 0 (ST_CLAMP_RD and
// ST_CLAMP_WR per node) and fills each further level (ST_LIFT_RD1, ST_LIFT_RD2 and
// ST_LIFT_WR per node and level), paced by the single read port of the table memory.
// A query beat (kind 1) walks min(LEVELS,16) levels of the table, one level per
// cycle, with an extra memory read state, ST_Q_LOAD, for each set bit of jump_count;
// before any build it returns node unchanged. The next beat is taken once the
// result has left the sequencer. Requests stall during a build or query.
// One result beat, end_node, comes out per query and none per load. The
// result sits in an output register; while the receiver stalls, the block
// still takes load beats, and a finished query waits until the register frees.
// node_count is written over the APB port at byte address 0; the user must write it
// only while the block is idle, as the block does not enforce this. Reset clears the
// control state and the built flag, sets node_count to 1024 and leaves the table memory.
module binary_lifting_jump_table
	import bljt_pkg::*;
#(
	parameter int NODES  = NODES_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Request channel.
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               kind,
	input  logic [NODE_W-1:0]  node,
	input  logic [NODE_W-1:0]  successor,
	input  logic [COUNT_W-1:0] jump_count,
	input  logic               last,
	// Result channel.
	output logic               res_valid,
	input  logic               res_stall,
	output logic [NODE_W-1:0]  end_node,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	localparam int CW = $clog2(NODES + 1);
	// Live node count after reset: the reset register value held to NODES.
	localparam int LIVE_RST = (NODE_COUNT_RST > NODES) ? NODES : NODE_COUNT_RST;

	logic [CFG_W-1:0] node_count_q;
	logic [CW-1:0]    live_n_q;
	logic             res_valid_q;
	logic [NODE_W-1:0] end_node_q;
	logic [NODE_W-1:0] res_node;
	logic             req_accept;
	logic             res_take;
	logic             cfg_write;
	bljt_status_t     status;

	// The live count is the register held to the range 1 to NODES.
	function automatic logic [CW-1:0] live_count(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return CW'(1);
		end else if (32'(v) > 32'(NODES)) begin
			return CW'(NODES);
		end
		return CW'(v);
	endfunction

	assign pready     = 1'b1;
	assign cfg_write  = psel && penable && pwrite && pready &&
		(paddr[APB_AW-1] == REG_NODE_COUNT);
	assign prdata     = (paddr[APB_AW-1] == REG_NODE_COUNT) ?
		APB_DW'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFG_W'(NODE_COUNT_RST);
			live_n_q     <= CW'(LIVE_RST);
		end else if (cfg_write) begin
			node_count_q <= pwdata[CFG_W-1:0];
			live_n_q     <= live_count(pwdata[CFG_W-1:0]);
		end
	end

	// Only an idle sequencer takes a request beat.
	assign req_stall  = !status.idle;
	assign req_accept = req_valid && !req_stall;

	// A finished query moves into the result register once it is empty or draining.
	assign res_take = !res_valid_q || !res_stall;

	bljt_ctrl #(
		.NODES (NODES),
		.LEVELS(LEVELS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (req_accept),
		.kind      (kind),
		.node      (node),
		.successor (successor),
		.jump_count(jump_count),
		.last      (last),
		.live_n    (live_n_q),
		.res_take  (res_take),
		.status    (status),
		.res_node  (res_node)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (status.res_valid && res_take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.res_valid && res_take) begin
			end_node_q <= res_node;
		end
	end

	assign res_valid = res_valid_q;
	assign end_node  = end_node_q;

endmodule

// ----- src/bljt_checker.sv -----
// Port-level checker for binary_lifting_jump_table, bound to the top level.
// Depends on bljt_pkg for field widths and item kinds.
module bljt_checker
	import bljt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              kind,
	input logic              res_valid,
	input logic              res_stall,
	input logic [NODE_W-1:0] end_node,
	input logic              pready
);

	logic req_fire;

	assign req_fire = req_valid && !req_stall;

	// No result beat is offered while reset is applied.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// A stalled result beat stays offered and unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(end_node))
		else $error("stalled result beat changed");

	// A query keeps the block busy in the cycle after it is taken.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (kind == KIND_QUERY) |=> req_stall)
		else $error("request taken while a query is in progress");

	// A load beat never produces a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (kind == KIND_LOAD) && !res_valid |=> !res_valid)
		else $error("result beat raised by a load");

	// The configuration port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind binary_lifting_jump_table bljt_checker u_bljt_checker (.*);
